FILE: design/mwd_pkg.sv
// Package for the moving window deconvolution filter.
// Holds field widths, register codes, reset values and output saturation.
// No dependencies.
package mwd_pkg;

  localparam int ACC_W      = 64;
  localparam int SAMPLE_W   = 16;
  localparam int OUT_W      = 40;
  localparam int CH_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WM_W       = 9;
  localparam int WL_W       = 8;
  localparam int DC_W       = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_M   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_L   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_COMP = 2'd2;

  localparam logic [WM_W-1:0] WINDOW_M_RST   = 9'd400;
  localparam logic [WL_W-1:0] WINDOW_L_RST   = 8'd200;
  localparam logic [DC_W-1:0] DECAY_COMP_RST = 32'd232161;

  localparam logic [ACC_W-1:0] OUT_POS_MAX = 64'h0000_007F_FFFF_FFFF;
  localparam logic [ACC_W-1:0] OUT_NEG_MAG = 64'h0000_0080_0000_0000;

  // Magnitude plus sign to a saturated two's complement output word.
  function automatic logic [OUT_W-1:0] out_sat(input logic [ACC_W-1:0] mag,
                                               input logic neg);
    logic [ACC_W-1:0] lim;
    logic [ACC_W-1:0] negv;
    if (!neg) begin
      lim = (mag > OUT_POS_MAX) ? OUT_POS_MAX : mag;
      return lim[OUT_W-1:0];
    end
    lim  = (mag > OUT_NEG_MAG) ? OUT_NEG_MAG : mag;
    negv = '0 - lim;
    return negv[OUT_W-1:0];
  endfunction

endpackage

FILE: design/mwd_div.sv
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
// Used by the filter top level for the window average. No dependencies.
module mwd_div #(
  parameter int DVW = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DVW-1:0] dividend_i,
  input  logic [7:0]     divisor_i,
  output logic           done_o,
  output logic [DVW-1:0] quot_o
);

  localparam int CNT_W = $clog2(DVW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVW-1:0]   dq_q, dq_d;
  logic [7:0]       rem_q, rem_d;
  logic [7:0]       dv_q, dv_d;
  logic [8:0]       rem_t;
  logic             qbit;

  assign rem_t = {rem_q, dq_q[DVW-1]};
  assign qbit  = (rem_t >= {1'b0, dv_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVW);
      dq_d   = dividend_i;
      rem_d  = '0;
      dv_d   = divisor_i;
    end else if (busy_q) begin
      rem_d = qbit ? 8'(rem_t - {1'b0, dv_q}) : rem_t[7:0];
      dq_d  = {dq_q[DVW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

FILE: design/moving_window_deconvolution_filter.sv
// Moving window deconvolution filter top level.
// Depends on mwd_pkg and mwd_div.
//
// Input channel: in_valid_i / in_stall_o with channel_i and sample_i. A word is
// taken when valid is high and stall is low. One sample is worked at a time.
// Output channel: out_valid_o / out_stall_i with out_channel_o, filtered_o and
// warming_up_o, held in an output register; a new sample may be taken while a
// result still waits there.
// Config channel: cfg_valid_i / cfg_ready_o, index and data; always ready.
// An accepted sample goes through the states S_RD, S_ACC, S_DIF, S_SUM and
// S_MAG, then to S_FIN while warming up; otherwise the average goes first
// through the bit-serial divider in S_DIV, one bit per cycle. A new sample
// is taken only once the last one has gone from S_FIN back to S_IDLE; the
// divider and the read-modify-write of the two history memories set the pace.
// Reset: the history memories are cleared one entry per cycle, with
// in_stall_o high. Config writes are taken during that pass.
// A stalled receiver holds the output word; the block finishes the next
// sample and then waits in stall until the output register is free.
module moving_window_deconvolution_filter #(
  parameter int CHANNELS  = 4,
  parameter int MAX_M     = 512,
  parameter int MAX_L     = 256,
  parameter int FRAC_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [mwd_pkg::CH_W-1:0]              channel_i,
  input  logic signed [mwd_pkg::SAMPLE_W-1:0]   sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mwd_pkg::CH_W-1:0]              out_channel_o,
  output logic signed [mwd_pkg::OUT_W-1:0]      filtered_o,
  output logic                                  warming_up_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mwd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mwd_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  localparam int AW     = mwd_pkg::ACC_W;
  localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW     = $clog2(MAX_M);
  localparam int MW     = $clog2(MAX_M + 1);
  localparam int LPW    = $clog2(MAX_L);
  localparam int DDEPTH = CHANNELS * MAX_M;
  localparam int LDEPTH = CHANNELS * MAX_L;
  localparam int DAW    = $clog2(DDEPTH);
  localparam int LAW    = $clog2(LDEPTH);
  localparam int CLRLEN = (DDEPTH > LDEPTH) ? DDEPTH : LDEPTH;
  localparam int CLW    = $clog2(CLRLEN);
  localparam int SH     = FRAC_BITS - 8;
  localparam int DVW    = AW - SH;
  localparam int PSH    = 32 - FRAC_BITS;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_DIF   = 4'd4;
  localparam logic [3:0] S_SUM   = 4'd5;
  localparam logic [3:0] S_MAG   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  function automatic logic [CHW-1:0] chan_mod(input logic [mwd_pkg::CH_W-1:0] c);
    logic [4:0] t;
    t = {3'b0, c};
    for (int i = 0; i < 3; i++) begin
      if (t >= 5'(CHANNELS)) t = t - 5'(CHANNELS);
    end
    return CHW'(t);
  endfunction

  // configuration
  logic [mwd_pkg::WM_W-1:0] window_m_q;
  logic [mwd_pkg::WL_W-1:0] window_l_q;
  logic [mwd_pkg::DC_W-1:0] decay_comp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_m_q   <= mwd_pkg::WINDOW_M_RST;
      window_l_q   <= mwd_pkg::WINDOW_L_RST;
      decay_comp_q <= mwd_pkg::DECAY_COMP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mwd_pkg::REG_WINDOW_M:   window_m_q   <= cfg_data_i[mwd_pkg::WM_W-1:0];
        mwd_pkg::REG_WINDOW_L:   window_l_q   <= cfg_data_i[mwd_pkg::WL_W-1:0];
        mwd_pkg::REG_DECAY_COMP: decay_comp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  logic [MW-1:0] m_eff;
  logic [7:0]    l_eff;
  always_comb begin
    if (window_m_q == '0) m_eff = MW'(1);
    else if (32'(window_m_q) > 32'(MAX_M)) m_eff = MW'(MAX_M);
    else m_eff = MW'(window_m_q);
    if (window_l_q == '0) l_eff = 8'd1;
    else if (32'(window_l_q) > 32'(MAX_L)) l_eff = 8'(MAX_L);
    else l_eff = window_l_q;
  end

  // per-channel state
  logic                       seen_q [CHANNELS];
  logic [mwd_pkg::SAMPLE_W-1:0] prev_q [CHANNELS];
  logic [AW-1:0]              acc_q  [CHANNELS];
  logic [AW-1:0]              sum_q  [CHANNELS];
  logic [PW-1:0]              wp_q   [CHANNELS];
  logic [LPW-1:0]             ap_q   [CHANNELS];
  logic [7:0]                 fill_q [CHANNELS];

  logic [3:0]   state_q, state_d;
  logic [CLW-1:0] clr_q;
  logic [CHW-1:0] ch_q;
  logic [mwd_pkg::SAMPLE_W-1:0] x_q;
  logic [AW-1:0] delta_q, prod_q, a_q, d_q, v_q;
  logic          warm_q, neg_q;
  logic [mwd_pkg::OUT_W-1:0] res_q;

  logic out_valid_q;
  logic [mwd_pkg::CH_W-1:0]  out_ch_q;
  logic [mwd_pkg::OUT_W-1:0] out_res_q;
  logic                      out_warm_q;

  // history memories
  logic [AW-1:0] dmem [DDEPTH];
  logic [AW-1:0] lmem [LDEPTH];
  logic          dwe, dre, lwe, lre;
  logic [DAW-1:0] dwa, dra;
  logic [LAW-1:0] lwa, lra;
  logic [AW-1:0]  dwd, lwd, drd_q, lrd_q;

  always_ff @(posedge clk_i) begin
    if (dwe) dmem[dwa] <= dwd;
    if (dre) drd_q <= dmem[dra];
  end
  always_ff @(posedge clk_i) begin
    if (lwe) lmem[lwa] <= lwd;
    if (lre) lrd_q <= lmem[lra];
  end

  // current channel views
  logic [PW-1:0]  wp_c, rp_c, wp_n;
  logic [LPW-1:0] ap_c, arp_c, ap_n;
  logic [MW:0]    rp_t;
  logic [LPW+1:0] arp_t;
  logic [mwd_pkg::SAMPLE_W:0] diff17;
  logic signed [48:0] prod_full;
  logic [AW-1:0] prod_ext, a_new, sum_new, mag, qsh;
  logic [7:0]    fill_n;
  logic          warm_n;

  assign wp_c = wp_q[ch_q];
  assign ap_c = ap_q[ch_q];
  always_comb begin
    rp_t = (MW+1)'(wp_c) + (MW+1)'(MAX_M) - (MW+1)'(m_eff);
    if (rp_t >= (MW+1)'(MAX_M)) rp_t = rp_t - (MW+1)'(MAX_M);
    rp_c = PW'(rp_t);
    arp_t = (LPW+2)'(ap_c) + (LPW+2)'(MAX_L) - (LPW+2)'(l_eff);
    if (arp_t >= (LPW+2)'(MAX_L)) arp_t = arp_t - (LPW+2)'(MAX_L);
    arp_c = LPW'(arp_t);
    wp_n = (32'(wp_c) == MAX_M - 1) ? '0 : wp_c + 1'b1;
    ap_n = (32'(ap_c) == MAX_L - 1) ? '0 : ap_c + 1'b1;
  end

  assign diff17 = {x_q[mwd_pkg::SAMPLE_W-1], x_q}
                - {prev_q[ch_q][mwd_pkg::SAMPLE_W-1], prev_q[ch_q]};
  assign prod_full = $signed({1'b0, decay_comp_q}) * $signed(prev_q[ch_q]);
  // floor of c*x_prev down to FRAC_BITS fraction bits
  assign prod_ext = $signed({{(AW-49){prod_full[48]}}, prod_full}) >>> PSH;
  assign a_new = seen_q[ch_q] ? acc_q[ch_q] + delta_q + prod_q
                              : {{(AW-mwd_pkg::SAMPLE_W){x_q[mwd_pkg::SAMPLE_W-1]}}, x_q}
                                << FRAC_BITS;
  assign sum_new = sum_q[ch_q] + d_q - lrd_q;
  assign fill_n  = (fill_q[ch_q] == 8'hFF) ? fill_q[ch_q] : fill_q[ch_q] + 8'd1;
  assign warm_n  = fill_n < l_eff;
  assign mag     = v_q[AW-1] ? '0 - v_q : v_q;
  assign qsh     = mag >> SH;

  logic           div_start, div_done;
  logic [DVW-1:0] div_quot;

  mwd_div #(.DVW(DVW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (qsh[DVW-1:0]),
    .divisor_i  (l_eff),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign div_start = (state_q == S_MAG) && !warm_q;

  always_comb begin
    dwe = 1'b0; dwa = DAW'(wp_c) + DAW'(ch_q) * DAW'(MAX_M); dwd = a_q;
    dre = 1'b0; dra = DAW'(rp_c) + DAW'(ch_q) * DAW'(MAX_M);
    lwe = 1'b0; lwa = LAW'(ap_c) + LAW'(ch_q) * LAW'(MAX_L); lwd = d_q;
    lre = 1'b0; lra = LAW'(arp_c) + LAW'(ch_q) * LAW'(MAX_L);
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        dwe = 32'(clr_q) < DDEPTH;
        dwa = DAW'(clr_q);
        dwd = '0;
        lwe = 32'(clr_q) < LDEPTH;
        lwa = LAW'(clr_q);
        lwd = '0;
        if (32'(clr_q) == CLRLEN - 1) state_d = S_IDLE;
      end
      S_IDLE: if (in_valid_i) state_d = S_RD;
      S_RD: begin
        dre = 1'b1;
        lre = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: state_d = S_DIF;
      S_DIF: begin
        dwe = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        lwe = 1'b1;
        state_d = S_MAG;
      end
      S_MAG: state_d = warm_q ? S_FIN : S_DIV;
      S_DIV: if (div_done) state_d = S_FIN;
      S_FIN: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        seen_q[i] <= 1'b0;
        prev_q[i] <= '0;
        acc_q[i]  <= '0;
        sum_q[i]  <= '0;
        wp_q[i]   <= '0;
        ap_q[i]   <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_ACC) begin
        seen_q[ch_q] <= 1'b1;
        prev_q[ch_q] <= x_q;
        acc_q[ch_q]  <= a_new;
      end
      if (state_q == S_DIF) wp_q[ch_q] <= wp_n;
      if (state_q == S_SUM) begin
        sum_q[ch_q]  <= sum_new;
        ap_q[ch_q]   <= ap_n;
        fill_q[ch_q] <= fill_n;
      end
      if (state_q == S_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q <= chan_mod(channel_i);
      x_q  <= sample_i;
    end
    if (state_q == S_RD) begin
      prod_q  <= prod_ext;
      delta_q <= {{(AW-mwd_pkg::SAMPLE_W-1){diff17[mwd_pkg::SAMPLE_W]}}, diff17}
                 << FRAC_BITS;
    end
    if (state_q == S_ACC) a_q <= a_new;
    if (state_q == S_DIF) d_q <= a_q - drd_q;
    if (state_q == S_SUM) begin
      v_q    <= warm_n ? d_q : sum_new;
      warm_q <= warm_n;
    end
    if (state_q == S_MAG) begin
      neg_q <= v_q[AW-1];
      if (warm_q) res_q <= mwd_pkg::out_sat(qsh, v_q[AW-1]);
    end
    if (state_q == S_DIV && div_done)
      res_q <= mwd_pkg::out_sat(AW'(div_quot), neg_q);
    if (state_q == S_FIN && out_free) begin
      out_ch_q   <= mwd_pkg::CH_W'(ch_q);
      out_res_q  <= res_q;
      out_warm_q <= warm_q;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign filtered_o    = out_res_q;
  assign warming_up_o  = out_warm_q;

endmodule

FILE: design/mwd_checker.sv
// Port-level checker for the filter top level, with its bind statement.
// Depends on mwd_pkg and moving_window_deconvolution_filter.
module mwd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [mwd_pkg::OUT_W-1:0]       filtered_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_o))
    else $error("output word changed under stall");

  // one sample at a time: busy right after a word is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // a result never appears in the cycle after a word is taken
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config port not ready");

endmodule

bind moving_window_deconvolution_filter mwd_checker u_mwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .filtered_o  (filtered_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
